// ===== design/rrts_pkg.sv =====
// Package for the round-robin thread scheduler.
// Holds shared widths, codes, the controller state type and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;

   localparam int unsigned MAX_THREADS = 16;
   localparam int unsigned ID_W = 4;
   localparam int unsigned CNT_W = 5;
   localparam logic [CNT_W-1:0] EMPTY_MARK = CNT_W'(MAX_THREADS);

   // Thread states.
   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_READY = 2'd1;
   localparam logic [1:0] ST_SLEEP = 2'd2;
   localparam logic [1:0] ST_DEAD  = 2'd3;

   // Request types.
   localparam logic [2:0] REQ_CREATE = 3'd0;
   localparam logic [2:0] REQ_TICK   = 3'd1;
   localparam logic [2:0] REQ_YIELD  = 3'd2;
   localparam logic [2:0] REQ_EXIT   = 3'd3;
   localparam logic [2:0] REQ_JOIN   = 3'd4;
   localparam logic [2:0] REQ_CANCEL = 3'd5;

   // Result codes.
   localparam logic [1:0] RC_OK        = 2'd0;
   localparam logic [1:0] RC_NO_THREAD = 2'd1;
   localparam logic [1:0] RC_POOL_FULL = 2'd2;
   localparam logic [1:0] RC_FINISHED  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_JOIN,
      S_GIVEUP,
      S_WAKE_START,
      S_WAKE_CHECK,
      S_WAKE_LINK,
      S_WAKE_END,
      S_PICK,
      S_POP_CHK,
      S_RESP
   } ctrl_state_type;

   typedef enum logic [2:0] {
      SA_RUN,
      SA_TGT,
      SA_WALK,
      SA_RING,
      SA_ZERO,
      SA_NEW
   } addr_sel_type;

   typedef struct packed {
      logic         accept;
      addr_sel_type addr_sel;
      logic         st_wr;
      logic [1:0]   st_val;
      logic         push;
      logic         create;
      logic         t_load;
      logic         join_link;
      logic         w_load_first;
      logic         w_load_link;
      logic         wake_clear;
      logic         pop;
      logic         run_from_ring;
      logic         run_zero;
      logic         set_done;
      logic         code_wr;
      logic [1:0]   code_val;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req;
      logic       tick_en;
      logic       all_done;
      logic       nf_full;
      logic       tgt_unknown;
      logic       tgt_is_run;
      logic [1:0] st;
      logic       ring_empty;
      logic       cur_zero;
      logic       w_valid;
      logic       w_is_last;
      logic       steps_done;
   } status_type;

endpackage
`default_nettype wire

// ===== design/rrts_dp.sv =====
// Datapath of the thread scheduler: thread table, ready ring, join lists and result registers.
// Depends on rrts_pkg; driven by rrts_ctrl through cmd_type.
`timescale 1ns / 1ps
`default_nettype none
module rrts_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_timeslice_enable,
   input  wire logic [2:0]           req_type,
   input  wire logic [3:0]           req_target_id,
   input  wire rrts_pkg::cmd_type    cmd,
   output rrts_pkg::status_type      status,
   output logic [1:0]                rsp_result_code,
   output logic [3:0]                rsp_running_id,
   output logic [3:0]                rsp_new_id,
   output logic                      rsp_switched
);
   import rrts_pkg::*;

   logic [1:0]       thread_state_ff [MAX_THREADS];
   logic [1:0]       thread_state_in [MAX_THREADS];
   logic [CNT_W-1:0] first_ff [MAX_THREADS];
   logic [CNT_W-1:0] first_in [MAX_THREADS];
   logic [CNT_W-1:0] last_ff [MAX_THREADS];
   logic [CNT_W-1:0] last_in [MAX_THREADS];
   logic [ID_W-1:0]  ring_mem [MAX_THREADS];
   logic [CNT_W-1:0] link_mem [MAX_THREADS];

   logic [ID_W-1:0]  ring_rd_ff;
   logic [CNT_W-1:0] link_rd_ff;
   logic [ID_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]  run_ff, run_in, prev_ff, prev_in, tgt_ff, tgt_in, nid_ff, nid_in;
   logic [2:0]       req_ff, req_in;
   logic [CNT_W-1:0] nf_ff, nf_in;
   logic [ID_W-1:0]  t_ff, t_in;
   logic [CNT_W-1:0] w_ff, w_in, steps_ff, steps_in;
   logic             done_ff, done_in, en_ff, en_in;
   logic [1:0]       code_ff, code_in;
   logic [ID_W-1:0]  addr;
   logic             do_push, link_wr;

   always_comb begin
      case (cmd.addr_sel)
         SA_RUN:  addr = run_ff;
         SA_TGT:  addr = tgt_ff;
         SA_WALK: addr = w_ff[ID_W-1:0];
         SA_RING: addr = ring_rd_ff;
         SA_ZERO: addr = '0;
         SA_NEW:  addr = nf_ff[ID_W-1:0];
         default: addr = '0;
      endcase
   end

   assign do_push = cmd.push && (count_ff < EMPTY_MARK);
   assign link_wr = cmd.join_link && (first_ff[t_ff] < EMPTY_MARK)
                    && (last_ff[t_ff] < EMPTY_MARK);

   always_comb begin
      thread_state_in = thread_state_ff;
      first_in = first_ff;
      last_in = last_ff;
      if (cmd.st_wr) begin
         thread_state_in[addr] = cmd.st_val;
      end
      if (cmd.create) begin
         first_in[addr] = EMPTY_MARK;
         last_in[addr] = EMPTY_MARK;
      end
      if (cmd.join_link) begin
         if (!link_wr) begin
            first_in[t_ff] = {1'b0, run_ff};
         end
         last_in[t_ff] = {1'b0, run_ff};
      end
      if (cmd.wake_clear) begin
         first_in[t_ff] = EMPTY_MARK;
         last_in[t_ff] = EMPTY_MARK;
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = tail_ff + 1'b1;
         count_in = count_in + 1'b1;
      end
      if (cmd.pop) begin
         head_in = head_ff + 1'b1;
         count_in = count_in - 1'b1;
      end
      run_in = run_ff;
      if (cmd.run_from_ring) begin
         run_in = ring_rd_ff;
      end else if (cmd.run_zero) begin
         run_in = '0;
      end
      prev_in = cmd.accept ? run_ff : prev_ff;
      tgt_in = cmd.accept ? req_target_id : tgt_ff;
      req_in = cmd.accept ? req_type : req_ff;
      nid_in = nid_ff;
      if (cmd.accept) begin
         nid_in = '0;
      end else if (cmd.create) begin
         nid_in = nf_ff[ID_W-1:0];
      end
      nf_in = cmd.create ? nf_ff + 1'b1 : nf_ff;
      t_in = cmd.t_load ? addr : t_ff;
      w_in = w_ff;
      steps_in = steps_ff;
      if (cmd.w_load_first) begin
         w_in = first_ff[t_ff];
         steps_in = '0;
      end else if (cmd.w_load_link) begin
         w_in = link_rd_ff;
         steps_in = steps_ff + 1'b1;
      end
      done_in = done_ff | cmd.set_done;
      en_in = csr_valid ? csr_timeslice_enable : en_ff;
      code_in = code_ff;
      if (cmd.accept) begin
         code_in = RC_OK;
      end else if (cmd.code_wr) begin
         code_in = cmd.code_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_THREADS; i++) begin
            thread_state_ff[i] <= (i == 0) ? ST_READY : ST_FREE;
            first_ff[i] <= EMPTY_MARK;
            last_ff[i] <= EMPTY_MARK;
         end
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         run_ff <= '0;
         nf_ff <= CNT_W'(1);
         done_ff <= 1'b0;
         en_ff <= 1'b1;
      end else begin
         thread_state_ff <= thread_state_in;
         first_ff <= first_in;
         last_ff <= last_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         run_ff <= run_in;
         nf_ff <= nf_in;
         done_ff <= done_in;
         en_ff <= en_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      tgt_ff <= tgt_in;
      req_ff <= req_in;
      nid_ff <= nid_in;
      t_ff <= t_in;
      w_ff <= w_in;
      steps_ff <= steps_in;
      code_ff <= code_in;
   end

   // Ring and link memories: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (do_push) begin
         ring_mem[tail_ff] <= addr;
      end
      ring_rd_ff <= ring_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (link_wr) begin
         link_mem[last_ff[t_ff][ID_W-1:0]] <= {1'b0, run_ff};
      end
      link_rd_ff <= link_mem[w_ff[ID_W-1:0]];
   end

   always_comb begin
      status.req = req_ff;
      status.tick_en = en_ff;
      status.all_done = done_ff;
      status.nf_full = (nf_ff >= EMPTY_MARK);
      status.tgt_unknown = ({1'b0, tgt_ff} >= nf_ff);
      status.tgt_is_run = (tgt_ff == run_ff);
      status.st = thread_state_ff[addr];
      status.ring_empty = (count_ff == '0);
      status.cur_zero = (run_ff == '0);
      status.w_valid = (w_ff < EMPTY_MARK);
      status.w_is_last = (w_ff == last_ff[t_ff]);
      status.steps_done = (steps_ff >= EMPTY_MARK);
   end

   assign rsp_result_code = code_ff;
   assign rsp_running_id = run_ff;
   assign rsp_new_id = nid_ff;
   assign rsp_switched = (run_ff != prev_ff);

endmodule
`default_nettype wire

// ===== design/rrts_ctrl.sv =====
// Controller state machine of the thread scheduler.
// Depends on rrts_pkg; drives rrts_dp through cmd_type and reads status_type.
`timescale 1ns / 1ps
`default_nettype none
module rrts_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rrts_pkg::status_type status,
   output rrts_pkg::cmd_type         cmd
);
   import rrts_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           pick_after_ff, pick_after_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pick_after_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pick_after_ff <= pick_after_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      pick_after_in = pick_after_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            pick_after_in = 1'b0;
            state_in = S_RESP;
            if (!status.all_done) begin
               case (status.req)
                  REQ_TICK:  if (status.tick_en) state_in = S_GIVEUP;
                  REQ_YIELD, REQ_EXIT: state_in = S_GIVEUP;
                  REQ_JOIN: begin
                     if (!status.tgt_unknown && status.st != ST_DEAD) begin
                        state_in = S_JOIN;
                     end
                  end
                  REQ_CANCEL: begin
                     if (!status.tgt_unknown) begin
                        state_in = status.tgt_is_run ? S_GIVEUP : S_WAKE_START;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_JOIN: state_in = S_GIVEUP;
         S_GIVEUP: begin
            if (status.st == ST_DEAD) begin
               pick_after_in = 1'b1;
               state_in = S_WAKE_START;
            end else begin
               state_in = S_PICK;
            end
         end
         S_WAKE_START: state_in = S_WAKE_CHECK;
         S_WAKE_CHECK: begin
            if (!status.w_valid || status.steps_done || status.w_is_last) begin
               state_in = S_WAKE_END;
            end else begin
               state_in = S_WAKE_LINK;
            end
         end
         S_WAKE_LINK: state_in = S_WAKE_CHECK;
         S_WAKE_END: state_in = pick_after_ff ? S_PICK : S_RESP;
         S_PICK: state_in = status.ring_empty ? S_RESP : S_POP_CHK;
         S_POP_CHK: begin
            if (status.st != ST_DEAD && status.st != ST_FREE) begin
               state_in = S_RESP;
            end else begin
               state_in = S_PICK;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      cmd.addr_sel = SA_RUN;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.accept = req_valid;
         end
         S_DECODE: begin
            if (status.all_done) begin
               cmd.code_wr = 1'b1;
               cmd.code_val = RC_FINISHED;
            end else begin
               case (status.req)
                  REQ_CREATE: begin
                     cmd.addr_sel = SA_NEW;
                     if (status.nf_full) begin
                        cmd.code_wr = 1'b1;
                        cmd.code_val = RC_POOL_FULL;
                     end else begin
                        cmd.st_wr = 1'b1;
                        cmd.st_val = ST_READY;
                        cmd.push = 1'b1;
                        cmd.create = 1'b1;
                     end
                  end
                  REQ_EXIT: begin
                     cmd.st_wr = 1'b1;
                     cmd.st_val = ST_DEAD;
                  end
                  REQ_JOIN: begin
                     cmd.addr_sel = SA_TGT;
                     cmd.t_load = 1'b1;
                     if (status.tgt_unknown) begin
                        cmd.code_wr = 1'b1;
                        cmd.code_val = RC_NO_THREAD;
                     end
                  end
                  REQ_CANCEL: begin
                     cmd.addr_sel = SA_TGT;
                     cmd.t_load = 1'b1;
                     if (status.tgt_unknown) begin
                        cmd.code_wr = 1'b1;
                        cmd.code_val = RC_NO_THREAD;
                     end else begin
                        cmd.st_wr = 1'b1;
                        cmd.st_val = ST_DEAD;
                     end
                  end
                  default: cmd.addr_sel = SA_RUN;
               endcase
            end
         end
         S_JOIN: begin
            cmd.st_wr = 1'b1;
            cmd.st_val = ST_SLEEP;
            cmd.join_link = 1'b1;
         end
         S_GIVEUP: begin
            if (status.st == ST_DEAD) begin
               cmd.t_load = 1'b1;
            end else if (status.st != ST_SLEEP) begin
               cmd.push = 1'b1;
            end
         end
         S_WAKE_START: cmd.w_load_first = 1'b1;
         S_WAKE_CHECK: begin
            cmd.addr_sel = SA_WALK;
            if (status.w_valid && !status.steps_done && status.st == ST_SLEEP) begin
               cmd.st_wr = 1'b1;
               cmd.st_val = ST_READY;
               cmd.push = 1'b1;
            end
         end
         S_WAKE_LINK: cmd.w_load_link = 1'b1;
         S_WAKE_END: cmd.wake_clear = 1'b1;
         S_PICK: begin
            cmd.addr_sel = SA_ZERO;
            if (status.ring_empty) begin
               cmd.run_zero = 1'b1;
               cmd.code_wr = 1'b1;
               if (status.cur_zero || status.st == ST_DEAD) begin
                  cmd.set_done = 1'b1;
                  cmd.code_val = RC_FINISHED;
               end else begin
                  cmd.st_wr = 1'b1;
                  cmd.st_val = ST_READY;
                  cmd.code_val = RC_OK;
               end
            end else begin
               cmd.pop = 1'b1;
            end
         end
         S_POP_CHK: begin
            cmd.addr_sel = SA_RING;
            if (status.st != ST_DEAD && status.st != ST_FREE) begin
               cmd.st_wr = 1'b1;
               cmd.st_val = ST_READY;
               cmd.run_from_ring = 1'b1;
            end
         end
         S_RESP: rsp_valid = 1'b1;
         default: cmd.addr_sel = SA_RUN;
      endcase
   end

endmodule
`default_nettype wire

// ===== design/round_robin_thread_scheduler_top.sv =====
// Top level of the round-robin thread scheduler with join.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
// A create or an event that only answers goes from accept through decode to its response; a
// yield also gives up the running thread and picks from the ring, skipping dead or free entries;
// a join also puts the caller to sleep, and an exit or cancel also walks the join list to wake joiners.
// Throughput: one event at a time; the next is accepted the cycle after the response beat.
// Reset (synchronous, active high) leaves main running, all other threads free, ticks enabled.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_thread_scheduler_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_timeslice_enable,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_type,
   input  wire logic [3:0] req_target_id,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_result_code,
   output logic [3:0]      rsp_running_id,
   output logic [3:0]      rsp_new_id,
   output logic            rsp_switched
);
   import rrts_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The control register is always writable; the user must write only while idle (not enforced by the block).
   assign csr_ready = 1'b1;

   // The controller walks each event through decode and, as the event needs, give-up, join-list wake and ring pick.
   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds thread states, the ready ring and the join lists.
   rrts_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_timeslice_enable (csr_timeslice_enable),
      .req_type             (req_type),
      .req_target_id        (req_target_id),
      .cmd                  (cmd),
      .status               (status),
      .rsp_result_code      (rsp_result_code),
      .rsp_running_id       (rsp_running_id),
      .rsp_new_id           (rsp_new_id),
      .rsp_switched         (rsp_switched)
   );

endmodule
`default_nettype wire

// ===== design/rrts_checker.sv =====
// Port-level checker for the thread scheduler, bound to the top level.
// Depends on rrts_pkg and round_robin_thread_scheduler_top.
`timescale 1ns / 1ps
`default_nettype none
module rrts_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_result_code,
   input wire logic [3:0] rsp_running_id,
   input wire logic [3:0] rsp_new_id,
   input wire logic       rsp_switched
);
   import rrts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_id)
      && $stable(rsp_result_code))
      else $error("response beat changed while stalled");

   a_no_same_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response appeared right after accept");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a response is pending");

   a_create_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_id != '0 |-> rsp_result_code == RC_OK && !rsp_switched)
      else $error("create response with bad code or switch");

endmodule

bind round_robin_thread_scheduler_top rrts_checker u_rrts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_code (rsp_result_code),
   .rsp_running_id  (rsp_running_id),
   .rsp_new_id      (rsp_new_id),
   .rsp_switched    (rsp_switched)
);
`default_nettype wire
